@@ hw/rtl/spg_pkg.sv @@
// ----------------------------------------------------------------------------
// Stepper pulse generator package
// Shared widths, command codes and bus layout for the step/dir generator.
// ----------------------------------------------------------------------------
package spg_pkg;

   localparam int unsigned STEP_W        = 15;
   localparam int unsigned CMP_W         = 16;
   localparam int unsigned TIMER_W_DEF   = 16;
   localparam int unsigned TIMER_W_MAX   = 32;

   // Request tdata: distance, direction, compare_value, homing, limit_hit.
   localparam int unsigned REQ_FIELDS_W  = STEP_W + 1 + CMP_W + 1 + 1;
   localparam int unsigned REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response tdata: step_out, dir_out, busy_res, homing_pending, steps_done,
   // limit_stop.
   localparam int unsigned RSP_FIELDS_W  = 4 + STEP_W + 1;
   localparam int unsigned RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_START = 1'b1
   } cmd_type;

   typedef struct packed {
      logic              limit_hit;
      logic              homing;
      logic [CMP_W-1:0]  compare_value;
      logic              direction;
      logic [STEP_W-1:0] distance;
   } req_fields_type;

   typedef struct packed {
      logic              limit_stop;
      logic [STEP_W-1:0] steps_done;
      logic              homing_pending;
      logic              busy_res;
      logic              dir_out;
      logic              step_out;
   } rsp_fields_type;

endpackage

@@ hw/rtl/stepper_pulse_generator_homing.sv @@
// ----------------------------------------------------------------------------
// Stepper step/dir pulse generator with homing stop
// One axis: clear-on-compare timer, step pin toggle, step count and limit stop.
// ----------------------------------------------------------------------------
// Each request transaction is either a timer tick (tuser = 0) or a start
// command (tuser = 1). A start latches distance, direction, compare value and
// homing flag and clears the timer count. While a move runs, each tick
// advances the timer; on a compare match the step pin toggles, and every
// falling edge of the step pin counts one full step. The move ends when the
// count reaches the distance or, in homing mode, when the limit switch reads
// 1 on a falling edge.
//
// Every request yields exactly one response transaction carrying the pin
// levels and status after that request. A request passes an input register
// and then the update logic into the response register, from which the
// response is driven. One request is taken in every cycle while the receiver
// keeps taking responses. If it stalls, the response register holds and
// the input register fills, after which req_tready drops until rsp_tready
// returns. Reset clears the axis to idle, step pin low, all counts zero,
// and empties both registers.
// ----------------------------------------------------------------------------
module stepper_pulse_generator_homing
   import spg_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = TIMER_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // distance[14:0], direction[15], compare_value[31:16], homing[32],
   // limit_hit[33], zero padding above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // step_out[0], dir_out[1], busy_res[2], homing_pending[3],
   // steps_done[18:4], limit_stop[19], zero padding above
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // Input register
   logic                   s1_valid_ff;
   cmd_type                s1_cmd_ff;
   req_fields_type         s1_req_ff;

   // Response register
   logic                   rsp_valid_ff;
   rsp_fields_type         rsp_ff;
   rsp_fields_type         rsp_in;

   // Axis state
   logic [TIMER_WIDTH-1:0] timer_ff,      timer_in;
   logic [TIMER_WIDTH-1:0] compare_ff,    compare_in;
   logic                   phase_ff,      phase_in;
   logic [STEP_W-1:0]      count_ff,      count_in;
   logic [STEP_W-1:0]      target_ff,     target_in;
   logic                   running_ff,    running_in;
   logic                   homing_ff,     homing_in;
   logic                   dir_ff,        dir_in;
   logic                   limit_stop_in;

   logic                   out_adv;
   logic                   s1_fire;
   logic [TIMER_W_MAX-1:0] cmp_wide;
   logic [STEP_W-1:0]      count_inc;

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_adv;
   assign req_tready = !s1_valid_ff || out_adv;

   assign cmp_wide  = {{(TIMER_W_MAX-CMP_W){1'b0}}, s1_req_ff.compare_value};
   assign count_inc = count_ff + STEP_W'(1);

   always_comb begin
      timer_in      = timer_ff;
      compare_in    = compare_ff;
      phase_in      = phase_ff;
      count_in      = count_ff;
      target_in     = target_ff;
      running_in    = running_ff;
      homing_in     = homing_ff;
      dir_in        = dir_ff;
      limit_stop_in = 1'b0;

      if (s1_cmd_ff == CMD_START) begin
         dir_in     = s1_req_ff.direction;
         target_in  = s1_req_ff.distance;
         compare_in = cmp_wide[TIMER_WIDTH-1:0];
         homing_in  = s1_req_ff.homing;
         timer_in   = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (timer_ff == compare_ff) begin
            timer_in = '0;
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               // Falling edge of the step pin completes one full step.
               phase_in = 1'b0;
               count_in = count_inc;
               if (count_inc >= target_ff) begin
                  count_in   = '0;
                  running_in = 1'b0;
               end
               if (s1_req_ff.limit_hit && homing_ff) begin
                  count_in      = '0;
                  running_in    = 1'b0;
                  homing_in     = 1'b0;
                  limit_stop_in = 1'b1;
               end
            end
         end else begin
            timer_in = timer_ff + TIMER_WIDTH'(1);
         end
      end

      rsp_in.step_out       = phase_in;
      rsp_in.dir_out        = dir_in;
      rsp_in.busy_res       = running_in;
      rsp_in.homing_pending = homing_in;
      rsp_in.steps_done     = count_in;
      rsp_in.limit_stop     = limit_stop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timer_ff     <= '0;
         compare_ff   <= '0;
         phase_ff     <= 1'b0;
         count_ff     <= '0;
         target_ff    <= '0;
         running_ff   <= 1'b0;
         homing_ff    <= 1'b0;
         dir_ff       <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (out_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            timer_ff   <= timer_in;
            compare_ff <= compare_in;
            phase_ff   <= phase_in;
            count_ff   <= count_in;
            target_ff  <= target_in;
            running_ff <= running_in;
            homing_ff  <= homing_in;
            dir_ff     <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff <= cmd_type'(req_tuser);
         s1_req_ff <= req_fields_type'(req_tdata[REQ_FIELDS_W-1:0]);
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, rsp_ff};

   // An idle axis always has its step count cleared.
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> count_ff == '0)
      else $error("step count non-zero while idle");

   // The timer never runs past the compare value.
   a_timer_bound: assert property (@(posedge clock) disable iff (reset)
      timer_ff <= compare_ff)
      else $error("timer count above compare value");

   // A limit stop ends the move and clears homing in the same response.
   a_limit_stop_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.limit_stop |-> !rsp_ff.busy_res && !rsp_ff.homing_pending)
      else $error("limit stop left move running or homing set");

   // The axis state moves only when a transaction is processed.
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(running_ff) && $stable(phase_ff) && $stable(count_ff))
      else $error("axis state changed without a transaction");

endmodule

@@ test/tb_stepper_pulse_generator_homing.sv @@
// ----------------------------------------------------------------------------
// Stepper pulse generator testbench
// Drives tick and start transactions into the step/dir generator, predicts
// the pin levels and status after each one, and checks every response.
// ----------------------------------------------------------------------------
module tb_stepper_pulse_generator_homing;
   import spg_pkg::*;

   typedef struct packed {
      cmd_type        cmd;
      req_fields_type f;
   } axis_cmd_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   stepper_pulse_generator_homing dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   axis_cmd_type   pending_cmds[$];
   rsp_fields_type expected_pins[$];
   axis_cmd_type   cmd_on_bus;
   int unsigned    total_cmds    = 0;
   int unsigned    accepted_cmds = 0;
   int unsigned    pins_seen     = 0;
   int unsigned    error_count   = 0;
   int unsigned    burst_left    = 0;
   int unsigned    gap_left      = 0;

   // Axis state as the generator should hold it.
   logic [15:0]       ax_timer   = '0;
   logic [15:0]       ax_compare = '0;
   logic              ax_phase   = 1'b0;
   logic [STEP_W-1:0] ax_steps   = '0;
   logic [STEP_W-1:0] ax_target  = '0;
   logic              ax_running = 1'b0;
   logic              ax_homing  = 1'b0;
   logic              ax_dir     = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Applies one transaction to the axis state and returns the pin levels.
   function automatic rsp_fields_type next_pin_state(axis_cmd_type c);
      rsp_fields_type r;
      logic           at_limit;
      at_limit = 1'b0;
      if (c.cmd == CMD_START) begin
         ax_dir     = c.f.direction;
         ax_target  = c.f.distance;
         ax_compare = c.f.compare_value;
         ax_homing  = c.f.homing;
         ax_timer   = '0;
         ax_running = 1'b1;
      end else if (ax_running) begin
         if (ax_timer == ax_compare) begin
            ax_timer = '0;
            if (!ax_phase) begin
               ax_phase = 1'b1;
            end else begin
               // Falling edge of the step pin: one full step is complete.
               ax_phase = 1'b0;
               ax_steps = ax_steps + 1'b1;
               if (ax_steps >= ax_target) begin
                  ax_steps   = '0;
                  ax_running = 1'b0;
               end
               if (c.f.limit_hit && ax_homing) begin
                  ax_steps   = '0;
                  ax_running = 1'b0;
                  ax_homing  = 1'b0;
                  at_limit   = 1'b1;
               end
            end
         end else begin
            ax_timer = ax_timer + 1'b1;
         end
      end
      r.step_out       = ax_phase;
      r.dir_out        = ax_dir;
      r.busy_res       = ax_running;
      r.homing_pending = ax_homing;
      r.steps_done     = ax_steps;
      r.limit_stop     = at_limit;
      return r;
   endfunction

   task automatic add_cmd(cmd_type c, int unsigned move_len, bit dir, int unsigned cmpv,
                          bit hom, bit lim);
      axis_cmd_type a;
      a.cmd             = c;
      a.f.distance      = move_len[STEP_W-1:0];
      a.f.direction     = dir;
      a.f.compare_value = cmpv[CMP_W-1:0];
      a.f.homing        = hom;
      a.f.limit_hit     = lim;
      pending_cmds.push_back(a);
      total_cmds++;
   endtask

   // Ticks carry random filler in the fields that only a start reads.
   task automatic add_tick(bit lim);
      add_cmd(CMD_TICK, $urandom, $urandom_range(0, 1), $urandom, $urandom_range(0, 1), lim);
   endtask

   initial begin
      int unsigned counted;
      int unsigned move_len;
      int unsigned cmpv;
      int unsigned full_move;
      int unsigned ticks;
      int unsigned sel;
      bit          hom;

      // Tick while idle, with every data bit set.
      add_cmd(CMD_TICK, 32'h7FFF, 1'b1, 32'hFFFF, 1'b1, 1'b1);
      // Zero distance ends at the first falling edge.
      add_cmd(CMD_START, 0, 1'b1, 0, 1'b0, 1'b0);
      add_tick(1'b0);
      add_tick(1'b0);
      // Homing: limit on a rising edge is ignored, then both stops at once.
      add_cmd(CMD_START, 1, 1'b0, 0, 1'b1, 1'b0);
      add_tick(1'b1);
      add_tick(1'b1);
      // Largest distance and compare value.
      add_cmd(CMD_START, 32767, 1'b1, 65535, 1'b1, 1'b1);
      add_tick(1'b1);
      add_tick(1'b0);
      // Start while running, then run the move to its end.
      add_cmd(CMD_START, 2, 1'b0, 1, 1'b0, 1'b0);
      for (int i = 0; i < 9; i++) add_tick(i[0]);
      // Homing stop before the distance is reached, then a tick while idle.
      add_cmd(CMD_START, 3, 1'b1, 0, 1'b1, 1'b0);
      add_tick(1'b0);
      add_tick(1'b1);
      add_tick(1'b1);

      counted = 0;
      while (counted < 1550) begin
         sel = $urandom_range(0, 19);
         if (sel < 2) begin
            // Noise: a few ticks with no fresh start.
            repeat ($urandom_range(1, 4)) add_tick($urandom_range(0, 1));
         end else begin
            sel = $urandom_range(0, 9);
            move_len = (sel < 7) ? $urandom_range(0, 6) :
                       (sel < 9) ? $urandom_range(7, 40) : $urandom_range(0, 32767);
            sel = $urandom_range(0, 9);
            cmpv = (sel < 6) ? $urandom_range(0, 2) :
                   (sel < 9) ? $urandom_range(3, 8) : $urandom_range(0, 65535);
            hom = $urandom_range(0, 1);
            add_cmd(CMD_START, move_len, $urandom_range(0, 1), cmpv, hom,
                    $urandom_range(0, 1));
            full_move = (cmpv > 29 || move_len > 29) ? 60 :
                        2 * (cmpv + 1) * (move_len + 1);
            if (full_move > 60) full_move = 60;
            // Most moves run to completion; some are cut short by the next start.
            if ($urandom_range(0, 3) != 0) ticks = full_move + $urandom_range(0, 3);
            else ticks = $urandom_range(1, full_move);
            for (int i = 0; i < ticks; i++) begin
               if (hom) add_tick($urandom_range(0, 5) == 0);
               else add_tick($urandom_range(0, 1));
            end
            counted += ticks + 1;
         end
      end

      while (accepted_cmds < total_cmds || expected_pins.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_stepper_pulse_generator_homing OK");
      end else begin
         $display("tb_stepper_pulse_generator_homing NOT OK");
      end
      $finish;
   end

   initial begin
      #(20 * 400000);
      $display("tb_stepper_pulse_generator_homing NOT OK");
      $finish;
   end

   // Sender: bursts of back-to-back transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_pins.push_back(next_pin_state(cmd_on_bus));
            accepted_cmds++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.cmd;
               req_tdata  <= {{(REQ_DATA_W - REQ_FIELDS_W){1'b0}}, cmd_on_bus.f};
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: the stall pattern is redrawn at random from three modes, and one long
   // hold-off lets the generator fill up and push back on its input.
   int unsigned rx_cycle  = 0;
   int unsigned stall_mode = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_FIELDS_W-1:0];
            pins_seen++;
            if (expected_pins.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("response transaction with nothing expected: %h", rsp_tdata);
            end else begin
               want = expected_pins.pop_front();
               if (got.step_out !== want.step_out || got.dir_out !== want.dir_out ||
                   got.busy_res !== want.busy_res ||
                   got.homing_pending !== want.homing_pending ||
                   got.steps_done !== want.steps_done ||
                   got.limit_stop !== want.limit_stop) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"response %0d mismatch: expected step %b dir %b busy %b ",
                               "homing %b steps %0d limit %b, got step %b dir %b busy %b ",
                               "homing %b steps %0d limit %b"}, pins_seen,
                              want.step_out, want.dir_out, want.busy_res,
                              want.homing_pending, want.steps_done, want.limit_stop,
                              got.step_out, got.dir_out, got.busy_res,
                              got.homing_pending, got.steps_done, got.limit_stop);
               end
            end
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
         if (!hold_done && pins_seen >= 500) begin
            hold_done = 1'b1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= rx_cycle[0];
            endcase
         end
      end
   end

endmodule

@@ stepper_pulse_generator_homing.f @@
hw/rtl/spg_pkg.sv
hw/rtl/stepper_pulse_generator_homing.sv
test/tb_stepper_pulse_generator_homing.sv
